/* design/ecpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_pkg - enhanced clock page replacer package
// Default sizes and request kind codes shared by the replacer.
// ----------------------------------------------------------------------------
package ecpr_pkg;

    localparam int FRAMES_DEF    = 4;
    localparam int PAGE_BITS_DEF = 20;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

endpackage

/* design/enhanced_clock_page_replacer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer - enhanced second-chance clock replacer
// Looks up one page request over FRAMES frames and, on a miss, picks a victim
// with the use/modify clock algorithm, one frame per cycle.
// ----------------------------------------------------------------------------
// A request (i_kind read/write, i_page) is taken when i_valid and o_ready are
// both high; o_ready is high only while the sequencer is idle. The frames are
// walked one per cycle by a single page comparator and a single use/modify
// test, all driven from one frame pointer. A hit ends the lookup and goes to
// the response state. A miss runs the full lookup, then the first pass
// (unused and clean), then, if that finds no victim, the second pass
// (unused, clearing use bits on the way), a fill and the response. The
// response sits in an output register, so a new request is taken while an
// earlier response still waits for i_ready; the block only stalls if it
// finishes a second response before the first is taken.
// Page numbers live in a small memory with a registered read port; frame
// valid, use and modify bits are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer #(
    parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF,
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [PAGE_BITS-1:0] i_page,
    // response channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [FW-1:0]        o_frame,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic                 o_evicted_dirty,
    output logic [FW-1:0]        o_hand
);

    localparam int CW = $clog2(FRAMES + 1);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,  // waiting for a request
        S_LOOKUP = 6'b000010,  // compare each resident page, from the hand
        S_SCAN1  = 6'b000100,  // first pass: unused and clean, or empty
        S_SCAN2  = 6'b001000,  // later passes: unused, clearing use bits
        S_FILL   = 6'b010000,  // install page into the victim frame
        S_RESP   = 6'b100000   // hand the response to the output register
    } t_state;

    function automatic logic [FW-1:0] f_inc(input logic [FW-1:0] a);
        f_inc = (a == FW'(FRAMES - 1)) ? '0 : a + 1'b1;
    endfunction

    // control state
    t_state              r_state,   n_state;
    logic [FW-1:0]       r_hand,    n_hand;
    logic [FRAMES-1:0]   r_valid,   n_valid;
    logic [FRAMES-1:0]   r_use,     n_use;
    logic [FRAMES-1:0]   r_mod,     n_mod;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_o_valid, n_o_valid;

    // working and payload registers
    logic [FW-1:0]        r_ptr,      n_ptr;
    logic [CW-1:0]        r_cnt,      n_cnt;
    logic [FW-1:0]        r_cmp_idx,  n_cmp_idx;
    logic                 r_cmp_last, n_cmp_last;
    logic                 r_kind,     n_kind;
    logic [PAGE_BITS-1:0] r_page,     n_page;
    logic                 r_res_hit,  n_res_hit;
    logic [FW-1:0]        r_res_frame, n_res_frame;
    logic                 r_res_evv,  n_res_evv;
    logic [PAGE_BITS-1:0] r_res_evp,  n_res_evp;
    logic                 r_res_evd,  n_res_evd;
    logic                 r_o_hit,    n_o_hit;
    logic [FW-1:0]        r_o_frame,  n_o_frame;
    logic                 r_o_evv,    n_o_evv;
    logic [PAGE_BITS-1:0] r_o_evp,    n_o_evp;
    logic                 r_o_evd,    n_o_evd;
    logic [FW-1:0]        r_o_hand,   n_o_hand;

    // page store
    logic [PAGE_BITS-1:0] r_mem [FRAMES];
    logic [PAGE_BITS-1:0] r_rd_page;
    logic                 w_mem_we;
    logic                 w_out_free;
    logic                 w_is_write;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_is_write = (r_kind == ecpr_pkg::KIND_WRITE);

    // registered read at the frame pointer; write on fill only
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_ptr] <= r_page;
        end
        r_rd_page <= r_mem[r_ptr];
    end

    always_comb begin
        n_state     = r_state;
        n_hand      = r_hand;
        n_valid     = r_valid;
        n_use       = r_use;
        n_mod       = r_mod;
        n_cmp_vld   = r_cmp_vld;
        n_o_valid   = r_o_valid;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_last  = r_cmp_last;
        n_kind      = r_kind;
        n_page      = r_page;
        n_res_hit   = r_res_hit;
        n_res_frame = r_res_frame;
        n_res_evv   = r_res_evv;
        n_res_evp   = r_res_evp;
        n_res_evd   = r_res_evd;
        n_o_hit     = r_o_hit;
        n_o_frame   = r_o_frame;
        n_o_evv     = r_o_evv;
        n_o_evp     = r_o_evp;
        n_o_evd     = r_o_evd;
        n_o_hand    = r_o_hand;
        w_mem_we    = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind    = i_kind;
                    n_page    = i_page;
                    n_ptr     = r_hand;
                    n_cnt     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // issue side: one read a cycle, FRAMES in all
                if (r_cnt != CW'(FRAMES)) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_idx  = r_ptr;
                    n_cmp_last = (r_cnt == CW'(FRAMES - 1));
                    n_ptr      = f_inc(r_ptr);
                    n_cnt      = r_cnt + 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                // compare side: data for the previous issue
                if (r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_page == r_page)) begin
                    n_use[r_cmp_idx] = 1'b1;
                    if (w_is_write) begin
                        n_mod[r_cmp_idx] = 1'b1;
                    end
                    n_res_hit   = 1'b1;
                    n_res_frame = r_cmp_idx;
                    n_res_evv   = 1'b0;
                    n_res_evp   = '0;
                    n_res_evd   = 1'b0;
                    n_state     = S_RESP;
                end else if (r_cmp_vld && r_cmp_last) begin
                    n_ptr   = r_hand;
                    n_cnt   = '0;
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (!r_valid[r_ptr] || (!r_use[r_ptr] && !r_mod[r_ptr])) begin
                    n_state = S_FILL;
                end else if (r_cnt == CW'(FRAMES - 1)) begin
                    n_ptr   = r_hand;
                    n_state = S_SCAN2;
                end else begin
                    n_ptr = f_inc(r_ptr);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN2: begin
                // ends at the latest back at its starting frame: every use bit passed is cleared
                if (!r_use[r_ptr]) begin
                    n_state = S_FILL;
                end else begin
                    n_use[r_ptr] = 1'b0;
                    n_ptr        = f_inc(r_ptr);
                end
            end
            S_FILL: begin
                w_mem_we      = 1'b1;
                n_res_hit     = 1'b0;
                n_res_frame   = r_ptr;
                n_res_evv     = r_valid[r_ptr];
                n_res_evp     = r_valid[r_ptr] ? r_rd_page : '0;
                n_res_evd     = r_valid[r_ptr] && r_mod[r_ptr];
                n_valid[r_ptr] = 1'b1;
                n_use[r_ptr]   = 1'b1;
                n_mod[r_ptr]   = w_is_write;
                n_hand         = f_inc(r_ptr);
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_res_hit;
                    n_o_frame = r_res_frame;
                    n_o_evv   = r_res_evv;
                    n_o_evp   = r_res_evp;
                    n_o_evd   = r_res_evd;
                    n_o_hand  = r_hand;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hand    <= '0;
            r_valid   <= '0;
            r_use     <= '0;
            r_mod     <= '0;
            r_cmp_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hand    <= n_hand;
            r_valid   <= n_valid;
            r_use     <= n_use;
            r_mod     <= n_mod;
            r_cmp_vld <= n_cmp_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_cnt       <= n_cnt;
        r_cmp_idx   <= n_cmp_idx;
        r_cmp_last  <= n_cmp_last;
        r_kind      <= n_kind;
        r_page      <= n_page;
        r_res_hit   <= n_res_hit;
        r_res_frame <= n_res_frame;
        r_res_evv   <= n_res_evv;
        r_res_evp   <= n_res_evp;
        r_res_evd   <= n_res_evd;
        r_o_hit     <= n_o_hit;
        r_o_frame   <= n_o_frame;
        r_o_evv     <= n_o_evv;
        r_o_evp     <= n_o_evp;
        r_o_evd     <= n_o_evd;
        r_o_hand    <= n_o_hand;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_frame         = r_o_frame;
    assign o_evicted_valid = r_o_evv;
    assign o_evicted_page  = r_o_evp;
    assign o_evicted_dirty = r_o_evd;
    assign o_hand          = r_o_hand;

`ifndef NO_ASSERTIONS
    // use and modify bits only ever sit on occupied frames
    a_use_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_use & ~r_valid) == '0)
        else $error("use bit set on an empty frame");

    a_mod_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mod & ~r_valid) == '0)
        else $error("modify bit set on an empty frame");

    // the filled frame is occupied and referenced, and the hand sits past it
    a_fill_installs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |=>
            r_valid[$past(r_ptr)] && r_use[$past(r_ptr)] &&
            (r_hand == f_inc($past(r_ptr))))
        else $error("fill did not install the victim frame");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted_valid && !o_evicted_dirty &&
                                (o_evicted_page == '0)))
        else $error("hit response carries eviction fields");
`endif

endmodule

/* test/enhanced_clock_page_replacer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer_tb - self-checking bench for the clock replacer
// Drives page requests (read/write, page number) through the valid/ready
// request channel, predicts every response with an own model of the
// enhanced second-chance clock and compares each response field by field.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacer_tb;

    localparam int FRAMES          = ecpr_pkg::FRAMES_DEF;
    localparam int PAGE_BITS       = ecpr_pkg::PAGE_BITS_DEF;
    localparam int FW              = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int HOLD_CYCLES     = 400;
    // longest correct quiet spell is the long receiver hold
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_SLACK     = 3 * FRAMES + 8;
    localparam int N_DIRECTED      = 20;

    typedef enum int {
        READY_MOSTLY,
        READY_PATTERN,
        READY_SPARSE,
        READY_ALWAYS
    } t_ready_mode;

    typedef struct {
        logic                 hit;
        logic [FW-1:0]        frame;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic                 ev_dirty;
        logic [FW-1:0]        hand;
    } t_replacer_reply;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own frame table and clock hand, works out the
    // response of each accepted request and checks responses in order.
    // ------------------------------------------------------------------------
    class t_page_replacer_scoreboard;
        logic [PAGE_BITS-1:0] frame_pages [FRAMES];
        bit                   frame_full  [FRAMES];
        bit                   use_flag    [FRAMES];
        bit                   mod_flag    [FRAMES];
        int unsigned          hand_pos;
        t_replacer_reply      awaited [$];
        int                   errors;
        int                   hits;
        int                   misses;
        int                   evictions;
        int                   dirty_evictions;
        int                   writes;

        function new();
            foreach (frame_pages[i]) begin
                frame_pages[i] = '0;
                frame_full[i]  = 1'b0;
                use_flag[i]    = 1'b0;
                mod_flag[i]    = 1'b0;
            end
            hand_pos        = 0;
            errors          = 0;
            hits            = 0;
            misses          = 0;
            evictions       = 0;
            dirty_evictions = 0;
            writes          = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(logic kind, logic [PAGE_BITS-1:0] page);
            t_replacer_reply want;
            int unsigned     f;
            int unsigned     k;
            bit              found;
            bit              chosen;
            want   = '{default: '0};
            found  = 1'b0;
            chosen = 1'b0;
            f      = 0;
            // empty frames never match, whatever page value they hold
            for (int i = 0; i < FRAMES; i++) begin
                k = (hand_pos + i) % FRAMES;
                if (!found && frame_full[k] && frame_pages[k] == page) begin
                    f     = k;
                    found = 1'b1;
                end
            end
            if (found) begin
                use_flag[f] = 1'b1;
                if (kind == ecpr_pkg::KIND_WRITE)
                    mod_flag[f] = 1'b1;
                hits++;
            end else begin
                // first pass: empty, or unused and clean
                for (int i = 0; i < FRAMES; i++) begin
                    k = (hand_pos + i) % FRAMES;
                    if (!chosen && (!frame_full[k] || (!use_flag[k] && !mod_flag[k]))) begin
                        f      = k;
                        chosen = 1'b1;
                    end
                end
                // later passes: first unused, clearing use bits passed over
                for (int i = 0; i < 2 * FRAMES && !chosen; i++) begin
                    k = (hand_pos + i) % FRAMES;
                    if (!use_flag[k]) begin
                        f      = k;
                        chosen = 1'b1;
                    end else begin
                        use_flag[k] = 1'b0;
                    end
                end
                if (!chosen)
                    f = hand_pos;
                if (frame_full[f]) begin
                    want.ev_valid = 1'b1;
                    want.ev_page  = frame_pages[f];
                    want.ev_dirty = mod_flag[f];
                    evictions++;
                    if (mod_flag[f])
                        dirty_evictions++;
                end
                frame_pages[f] = page;
                frame_full[f]  = 1'b1;
                use_flag[f]    = 1'b1;
                mod_flag[f]    = (kind == ecpr_pkg::KIND_WRITE);
                hand_pos       = (f + 1) % FRAMES;
                misses++;
            end
            if (kind == ecpr_pkg::KIND_WRITE)
                writes++;
            want.hit   = found;
            want.frame = FW'(f);
            want.hand  = FW'(hand_pos);
            awaited.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_reply(t_replacer_reply seen);
            t_replacer_reply want;
            if (awaited.size() == 0) begin
                $display("%0t: response with nothing expected, expected none,",
                         $time, " actual hit=%0b frame=%0d", seen.hit, seen.frame);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("hit", 64'(want.hit), 64'(seen.hit));
            compare_field("frame", 64'(want.frame), 64'(seen.frame));
            compare_field("evicted_valid", 64'(want.ev_valid), 64'(seen.ev_valid));
            compare_field("evicted_page", 64'(want.ev_page), 64'(seen.ev_page));
            compare_field("evicted_dirty", 64'(want.ev_dirty), 64'(seen.ev_dirty));
            compare_field("hand", 64'(want.hand), 64'(seen.hand));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_kind;
    logic [PAGE_BITS-1:0] i_page;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_hit;
    logic [FW-1:0]        o_frame;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic                 o_evicted_dirty;
    logic [FW-1:0]        o_hand;

    t_page_replacer_scoreboard sb;

    // receiver control, written by the main sequence, read by the receiver
    t_ready_mode ready_mode    = READY_MOSTLY;
    logic [7:0]  stall_pattern = 8'hb5;
    bit          hold_ask      = 1'b0;
    int          idle_cycles   = 0;
    int          n_sent        = 0;

    enhanced_clock_page_replacer #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_page          (i_page),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_frame         (o_frame),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_evicted_dirty (o_evicted_dirty),
        .o_hand          (o_hand)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Request driver. Payload moves at the falling edge; acceptance is seen
    // at the rising edge, where o_ready still holds its pre-edge value.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic kind, input logic [PAGE_BITS-1:0] page);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_page  <= page;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_request(kind, page);
        n_sent++;
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // sender pause: nothing new until every response is back
    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stalls on its own pattern per phase; one long hold-off,
    // counted here, lets the block fill up and push back on requests.
    // ------------------------------------------------------------------------
    initial begin
        int          hold_left;
        bit          hold_taken;
        int unsigned pat_idx;
        hold_left  = 0;
        hold_taken = 1'b0;
        pat_idx    = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            pat_idx++;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_MOSTLY:  i_ready <= ($urandom_range(0, 3) != 0);
                    READY_PATTERN: i_ready <= stall_pattern[3'(pat_idx % 8)];
                    READY_SPARSE:  i_ready <= ($urandom_range(0, 3) == 0);
                    default:       i_ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_replacer_reply seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen = '{hit: o_hit, frame: o_frame, ev_valid: o_evicted_valid,
                     ev_page: o_evicted_page, ev_dirty: o_evicted_dirty, hand: o_hand};
            sb.check_reply(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too long without any handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles,",
                         $time, idle_cycles, " %0d responses outstanding", sb.pending());
                $display("enhanced_clock_page_replacer_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    // Directed requests: page zero into empty frames (must not hit), both page
    // extremes, read and write hits, a miss with every use bit set (second
    // pass clears them), misses with dirty frames and hits after eviction.
    logic [PAGE_BITS-1:0] directed_page [N_DIRECTED] = '{
        20'h00000, 20'hfffff, 20'h00000, 20'h00000, 20'h12345,
        20'habcde, 20'hfffff, 20'h00001, 20'h12345, 20'h80000,
        20'h7ffff, 20'h00001, 20'h80000, 20'h55555, 20'haaaaa,
        20'h0ffff, 20'h0ffff, 20'hf0000, 20'h00000, 20'hfffff
    };
    logic directed_kind [N_DIRECTED] = '{
        ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_READ,
        ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_WRITE,
        ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_WRITE,
        ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_WRITE,
        ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_READ,
        ecpr_pkg::KIND_WRITE, ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_WRITE,
        ecpr_pkg::KIND_READ,  ecpr_pkg::KIND_WRITE
    };

    initial begin
        logic [PAGE_BITS-1:0] page_pool [8];
        logic [PAGE_BITS-1:0] page;
        logic                 kind;
        int                   pool_size;
        int                   write_pct;
        int                   sent_in_phase;
        int                   burst;
        int                   pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind  = ecpr_pkg::KIND_READ;
        i_page  = '0;
        sb      = new();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_kind[i], directed_page[i]);
        idle_for(1);
        wait_for_drain();

        // Random phases. Most requests come from a small pool of pages so that
        // hits, refills and evictions interleave; the rest are extremes and
        // fully random pages. The write share varies so that clean frames
        // (first pass) and all-dirty tables (later passes) both turn up.
        for (int phase = 0; phase < 4; phase++) begin
            ready_mode    = t_ready_mode'(phase);
            stall_pattern = 8'($urandom()) | 8'h01;
            pool_size     = $urandom_range(3, 8);
            foreach (page_pool[i])
                page_pool[i] = PAGE_BITS'($urandom());
            write_pct     = (phase == 0) ? 20 : (phase == 2) ? 80 : 50;
            if (phase == 1)
                hold_ask = 1'b1;
            sent_in_phase = 0;
            while (sent_in_phase < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        page = page_pool[$urandom_range(0, pool_size - 1)];
                    else if (pick < 80)
                        page = pick[0] ? '1 : '0;
                    else
                        page = PAGE_BITS'($urandom());
                    kind = ($urandom_range(0, 99) < write_pct) ?
                           ecpr_pkg::KIND_WRITE : ecpr_pkg::KIND_READ;
                    // now and then a pool page is swapped for a fresh one
                    if ($urandom_range(0, 31) == 0)
                        page_pool[$urandom_range(0, pool_size - 1)] = PAGE_BITS'($urandom());
                    send_request(kind, page);
                    sent_in_phase++;
                end
                // last phase runs back to back against an always-ready sink
                if (phase != 3)
                    idle_for($urandom_range(0, 8));
            end
            idle_for(1);
            wait_for_drain();
        end

        repeat (DRAIN_SLACK) @(posedge i_clk);

        $display("covered %0d requests (%0d writes): %0d hits, %0d misses",
                 n_sent, sb.writes, sb.hits, sb.misses);
        $display("%0d evictions, %0d of them dirty;", sb.evictions, sb.dirty_evictions,
                 " long receiver hold and drain pauses included");
        if (sb.pending() != 0)
            $display("%0t: %0d expected responses never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("enhanced_clock_page_replacer_tb OK");
        else
            $display("enhanced_clock_page_replacer_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
design/ecpr_pkg.sv
design/enhanced_clock_page_replacer.sv
test/enhanced_clock_page_replacer_tb.sv
